// File: rtl/leb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package leb_pkg;

	typedef logic [1:0] edge_t;
	typedef logic [2:0] slot_t;

	localparam edge_t EDGE_AB = 2'd0;
	localparam edge_t EDGE_BC = 2'd1;
	localparam edge_t EDGE_CA = 2'd2;

	localparam slot_t SLOT_VTX_A = 3'd0;
	localparam slot_t SLOT_VTX_B = 3'd1;
	localparam slot_t SLOT_VTX_C = 3'd2;
	localparam slot_t SLOT_MID   = 3'd3;
	localparam slot_t SLOT_LEFT  = 3'd4;
	localparam slot_t SLOT_RIGHT = 3'd5;

	localparam logic KIND_VERTEX   = 1'b0;
	localparam logic KIND_TRIANGLE = 1'b1;

	localparam int unsigned MID_CORNER      = 3;
	localparam int unsigned VERTS_PER_SPLIT = 4;

	function automatic edge_t edge_next(input edge_t e);
		edge_t r;
		case (e)
			EDGE_AB: r = EDGE_BC;
			EDGE_BC: r = EDGE_CA;
			default: r = EDGE_AB;
		endcase
		return r;
	endfunction

	function automatic edge_t edge_after(input edge_t e);
		edge_t r;
		case (e)
			EDGE_AB: r = EDGE_CA;
			EDGE_BC: r = EDGE_AB;
			default: r = EDGE_BC;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/leb_intf.sv
`timescale 1ns / 1ps
`default_nettype none

interface leb_tri_if #(
	parameter int COORD_BITS = 24
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] a_x;
	logic signed [COORD_BITS-1:0] a_y;
	logic signed [COORD_BITS-1:0] a_z;
	logic signed [COORD_BITS-1:0] b_x;
	logic signed [COORD_BITS-1:0] b_y;
	logic signed [COORD_BITS-1:0] b_z;
	logic signed [COORD_BITS-1:0] c_x;
	logic signed [COORD_BITS-1:0] c_y;
	logic signed [COORD_BITS-1:0] c_z;

	modport source (
		output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		input  ready
	);
	modport sink (
		input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
		output ready
	);
endinterface

interface leb_res_if #(
	parameter int COORD_BITS = 24,
	parameter int INDEX_BITS = 32
) ();
	logic                         valid;
	logic                         ready;
	logic                         item_kind;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic signed [COORD_BITS-1:0] pos_z;
	logic [INDEX_BITS-1:0]        corner_one;
	logic [INDEX_BITS-1:0]        corner_two;
	logic [INDEX_BITS-1:0]        corner_three;
	logic                         last_of_run;

	modport source (
		output valid, item_kind, pos_x, pos_y, pos_z,
		output corner_one, corner_two, corner_three, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, item_kind, pos_x, pos_y, pos_z,
		input  corner_one, corner_two, corner_three, last_of_run,
		output ready
	);
endinterface

`default_nettype wire

// File: rtl/longest_edge_bisection_top.sv
`timescale 1ns / 1ps
`default_nettype none
// The first result of a triangle is offered once it has passed the input, squares and split registers.
// The six results of a triangle follow on consecutive cycles when the sink is ready.
// The result channel moves one result a cycle while the sink is ready, and so sets the triangle rate.
// A three-stage pipeline (input, squares, split) lets new triangles enter while results drain.
// Reset clears the stage valid flags, the result slot counter and the vertex base to zero.

module longest_edge_bisection_top #(
	parameter int COORD_BITS = 24,
	parameter int INDEX_BITS = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	leb_tri_if.sink     triangle,
	leb_res_if.source   result
);

	localparam int SQ_BITS  = 2 * COORD_BITS;
	localparam int LEN_BITS = SQ_BITS + 2;
	localparam logic [INDEX_BITS-1:0] IDX_MID  = INDEX_BITS'(leb_pkg::MID_CORNER);
	localparam logic [INDEX_BITS-1:0] IDX_STEP = INDEX_BITS'(leb_pkg::VERTS_PER_SPLIT);

	// Stage 1: input register.
	logic                         valid_s1;
	logic signed [COORD_BITS-1:0] vtx_s1 [3][3];

	// Stage 2: per-component squared differences.
	logic                         valid_s2;
	logic signed [COORD_BITS-1:0] vtx_s2 [3][3];
	logic [SQ_BITS-1:0]           sq_s2  [3][3];

	// Stage 3: result holding register.
	logic                         valid_s3;
	logic signed [COORD_BITS-1:0] vtx_s3 [3][3];
	logic signed [COORD_BITS-1:0] mid_s3 [3];
	logic [INDEX_BITS-1:0]        base_s3;
	leb_pkg::edge_t               longest_s3;

	logic [INDEX_BITS-1:0]        vertex_base_q;
	leb_pkg::slot_t               slot_q;

	logic ready_s1;
	logic ready_s2;
	logic ready_s3;
	logic in_acc;
	logic res_acc;
	logic last_slot;

	logic [SQ_BITS-1:0]           sq_next [3][3];
	logic [LEN_BITS-1:0]          len     [3];
	leb_pkg::edge_t               longest;
	logic [LEN_BITS-1:0]          best01;
	logic signed [COORD_BITS-1:0] mid_next [3];

	assign res_acc   = result.valid & result.ready;
	assign last_slot = (slot_q == leb_pkg::SLOT_RIGHT);
	assign ready_s3  = ~valid_s3 | (res_acc & last_slot);
	assign ready_s2  = ~valid_s2 | ready_s3;
	assign ready_s1  = ~valid_s1 | ready_s2;
	assign in_acc    = triangle.valid & ready_s1;
	assign triangle.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= triangle.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			vtx_s1[0][0] <= triangle.a_x;
			vtx_s1[0][1] <= triangle.a_y;
			vtx_s1[0][2] <= triangle.a_z;
			vtx_s1[1][0] <= triangle.b_x;
			vtx_s1[1][1] <= triangle.b_y;
			vtx_s1[1][2] <= triangle.b_z;
			vtx_s1[2][0] <= triangle.c_x;
			vtx_s1[2][1] <= triangle.c_y;
			vtx_s1[2][2] <= triangle.c_z;
		end
	end

	for (genvar e = 0; e < 3; e++) begin : g_edge
		localparam int NE = (e + 1) % 3;
		for (genvar k = 0; k < 3; k++) begin : g_comp
			logic signed [COORD_BITS:0] diff;
			logic signed [COORD_BITS:0] mag_full;
			logic [COORD_BITS-1:0]      mag;
			assign diff     = {vtx_s1[e][k][COORD_BITS-1], vtx_s1[e][k]}
				- {vtx_s1[NE][k][COORD_BITS-1], vtx_s1[NE][k]};
			assign mag_full = diff[COORD_BITS] ? -diff : diff;
			assign mag      = mag_full[COORD_BITS-1:0];
			assign sq_next[e][k] = SQ_BITS'(mag) * SQ_BITS'(mag);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			vtx_s2 <= vtx_s1;
			sq_s2  <= sq_next;
		end
	end

	always_comb begin
		for (int e = 0; e < 3; e++) begin
			len[e] = LEN_BITS'(sq_s2[e][0]) + LEN_BITS'(sq_s2[e][1])
				+ LEN_BITS'(sq_s2[e][2]);
		end
		if (len[1] > len[0]) begin
			longest = leb_pkg::EDGE_BC;
			best01  = len[1];
		end else begin
			longest = leb_pkg::EDGE_AB;
			best01  = len[0];
		end
		if (len[2] > best01) begin
			longest = leb_pkg::EDGE_CA;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic signed [COORD_BITS-1:0] p;
			logic signed [COORD_BITS-1:0] q;
			logic signed [COORD_BITS:0]   s;
			case (longest)
				leb_pkg::EDGE_AB: begin
					p = vtx_s2[0][k];
					q = vtx_s2[1][k];
				end
				leb_pkg::EDGE_BC: begin
					p = vtx_s2[1][k];
					q = vtx_s2[2][k];
				end
				default: begin
					p = vtx_s2[2][k];
					q = vtx_s2[0][k];
				end
			endcase
			s = {p[COORD_BITS-1], p} + {q[COORD_BITS-1], q};
			mid_next[k] = s[COORD_BITS:1];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			vtx_s3     <= vtx_s2;
			mid_s3     <= mid_next;
			base_s3    <= vertex_base_q;
			longest_s3 <= longest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_base_q <= '0;
			slot_q        <= leb_pkg::SLOT_VTX_A;
		end else begin
			if (valid_s2 && ready_s3) begin
				vertex_base_q <= vertex_base_q + IDX_STEP;
			end
			if (res_acc) begin
				slot_q <= last_slot ? leb_pkg::SLOT_VTX_A : slot_q + 3'd1;
			end
		end
	end

	logic [INDEX_BITS-1:0] idx_long;
	logic [INDEX_BITS-1:0] idx_next;
	logic [INDEX_BITS-1:0] idx_after;
	logic [INDEX_BITS-1:0] idx_mid;

	assign idx_long  = base_s3 + {{(INDEX_BITS-2){1'b0}}, longest_s3};
	assign idx_next  = base_s3 + {{(INDEX_BITS-2){1'b0}}, leb_pkg::edge_next(longest_s3)};
	assign idx_after = base_s3 + {{(INDEX_BITS-2){1'b0}}, leb_pkg::edge_after(longest_s3)};
	assign idx_mid   = base_s3 + IDX_MID;

	assign result.valid = valid_s3;

	always_comb begin
		result.item_kind    = leb_pkg::KIND_VERTEX;
		result.pos_x        = '0;
		result.pos_y        = '0;
		result.pos_z        = '0;
		result.corner_one   = '0;
		result.corner_two   = '0;
		result.corner_three = '0;
		result.last_of_run  = 1'b0;
		case (slot_q)
			leb_pkg::SLOT_VTX_A: begin
				result.pos_x = vtx_s3[0][0];
				result.pos_y = vtx_s3[0][1];
				result.pos_z = vtx_s3[0][2];
			end
			leb_pkg::SLOT_VTX_B: begin
				result.pos_x = vtx_s3[1][0];
				result.pos_y = vtx_s3[1][1];
				result.pos_z = vtx_s3[1][2];
			end
			leb_pkg::SLOT_VTX_C: begin
				result.pos_x = vtx_s3[2][0];
				result.pos_y = vtx_s3[2][1];
				result.pos_z = vtx_s3[2][2];
			end
			leb_pkg::SLOT_MID: begin
				result.pos_x = mid_s3[0];
				result.pos_y = mid_s3[1];
				result.pos_z = mid_s3[2];
			end
			leb_pkg::SLOT_LEFT: begin
				result.item_kind    = leb_pkg::KIND_TRIANGLE;
				result.corner_one   = idx_long;
				result.corner_two   = idx_mid;
				result.corner_three = idx_after;
			end
			leb_pkg::SLOT_RIGHT: begin
				result.item_kind    = leb_pkg::KIND_TRIANGLE;
				result.corner_one   = idx_mid;
				result.corner_two   = idx_next;
				result.corner_three = idx_after;
				result.last_of_run  = 1'b1;
			end
			default: begin
				result.item_kind = leb_pkg::KIND_VERTEX;
			end
		endcase
	end

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= leb_pkg::SLOT_RIGHT)
		else $error("Result slot counter out of range.");

	a_slot_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc && last_slot |=> slot_q == leb_pkg::SLOT_VTX_A)
		else $error("Slot counter did not restart after the last result.");

	a_base_step: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ready_s3 |=> vertex_base_q == $past(vertex_base_q) + IDX_STEP)
		else $error("Vertex base did not advance by one split.");

	a_base_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s2 && ready_s3) |=> vertex_base_q == $past(vertex_base_q))
		else $error("Vertex base changed without a new triangle.");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |-> !triangle.ready)
		else $error("Input request taken while stage one is blocked.");

	a_longest_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> longest_s3 <= leb_pkg::EDGE_CA)
		else $error("Longest edge code is not an edge.");

endmodule

`default_nettype wire
